// ===== rtl/core/ihds_pkg.sv =====
// Shared types, codes and constant tables for the image header dimension sniffer.
// No dependencies; every module refers to it by scoped names.
`timescale 1ns / 1ps

package ihds_pkg;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

   localparam logic [1:0] FORMAT_JPEG = 2'd0;
   localparam logic [1:0] FORMAT_PNG  = 2'd1;

   localparam logic [7:0] JPEG_FILL     = 8'hFF;
   localparam logic [7:0] JPEG_SOI      = 8'hD8;
   localparam logic [7:0] JPEG_EOI      = 8'hD9;
   localparam logic [7:0] JPEG_SOF_MASK = 8'hF0;
   localparam logic [7:0] JPEG_SOF_BASE = 8'hC0;
   localparam logic [7:0] JPEG_DHT      = 8'hC4;
   localparam logic [7:0] JPEG_JPG      = 8'hC8;
   localparam logic [7:0] JPEG_DAC      = 8'hCC;

   localparam logic [5:0] PNG_LAST_INDEX = 6'd32;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] image_width;
      logic [31:0] image_height;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type result;
   } parse_out_type;

   function automatic logic [7:0] png_signature_byte(input logic [2:0] idx);
      logic [7:0] value;
      unique case (idx)
         3'd0:    value = 8'd137;
         3'd1:    value = 8'd80;
         3'd2:    value = 8'd78;
         3'd3:    value = 8'd71;
         3'd4:    value = 8'd13;
         3'd5:    value = 8'd10;
         3'd6:    value = 8'd26;
         3'd7:    value = 8'd10;
         default: value = 8'd0;
      endcase
      return value;
   endfunction

   function automatic logic [7:0] png_tag_byte(input logic [1:0] idx);
      logic [7:0] value;
      unique case (idx)
         2'd0:    value = 8'h49;
         2'd1:    value = 8'h48;
         2'd2:    value = 8'h44;
         2'd3:    value = 8'h52;
         default: value = 8'd0;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/core/ihds_req_if.sv =====
// Byte input channel: valid/ready handshake with one file byte and its last flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface ihds_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/ihds_rsp_if.sv =====
// Result channel: valid/ready handshake with status, width and height.
// Depends on nothing.
`timescale 1ns / 1ps

interface ihds_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] image_width;
   logic [31:0] image_height;

   modport source (output valid, output status, output image_width, output image_height,
                   input ready);
   modport sink   (input valid, input status, input image_width, input image_height,
                   output ready);
endinterface

// ===== rtl/core/image_header_dimension_sniffer.sv =====
// Image header dimension sniffer: accepts one file byte per cycle while the result register is
// free, and returns one result per image (status, width, height) after the deciding byte is
// accepted, by way of the input register and then the result register. A result is
// produced on the byte that decides it; later bytes up to the last-byte flag are consumed
// without output. The format register is sampled on the first byte of each image.
// Depends on ihds_pkg, ihds_req_if, ihds_rsp_if, ihds_in_stage, ihds_parser, ihds_out_reg.
`timescale 1ns / 1ps

module image_header_dimension_sniffer (
   input  logic        clock,
   input  logic        reset,
   ihds_req_if.sink    req_if,
   ihds_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   logic                     item_valid;
   ihds_pkg::item_type       item;
   ihds_pkg::parse_out_type  parse_out;
   logic                     out_free;
   logic                     advance;

   assign advance = item_valid && out_free;

   ihds_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ihds_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .item        (item),
      .parse_out   (parse_out)
   );

   ihds_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .parse_out (parse_out),
      .free      (out_free),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== rtl/core/ihds_in_stage.sv =====
// Input register: captures one byte transaction and holds it until the parser advances.
// Depends on ihds_pkg and ihds_req_if.
`timescale 1ns / 1ps

module ihds_in_stage (
   input  logic                clock,
   input  logic                reset,
   ihds_req_if.sink            req_if,
   input  logic                advance,
   output logic                item_valid,
   output ihds_pkg::item_type  item
);

   logic               valid_ff;
   logic               valid_in;
   ihds_pkg::item_type item_ff;
   logic               take;

   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte <= req_if.data_byte;
         item_ff.last_byte <= req_if.last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/ihds_parser.sv =====
// Header parser: phase register, counters and accumulators, one byte per advance.
// Holds the format register. Depends on ihds_pkg.
`timescale 1ns / 1ps

module ihds_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_wr_data,
   input  logic                     advance,
   input  ihds_pkg::item_type       item,
   output ihds_pkg::parse_out_type  parse_out
);

   localparam logic [3:0] PH_START  = 4'd0;
   localparam logic [3:0] PH_J_SOI1 = 4'd1;
   localparam logic [3:0] PH_J_SEEK = 4'd2;
   localparam logic [3:0] PH_J_FILL = 4'd3;
   localparam logic [3:0] PH_J_LENH = 4'd4;
   localparam logic [3:0] PH_J_LENL = 4'd5;
   localparam logic [3:0] PH_J_SKIP = 4'd6;
   localparam logic [3:0] PH_J_SOF  = 4'd7;
   localparam logic [3:0] PH_PNG    = 4'd8;
   localparam logic [3:0] PH_DONE   = 4'd9;

   logic [1:0]  format_ff;
   logic [3:0]  phase_ff,  phase_in;
   logic [15:0] count_ff,  count_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [31:0] acc_w_ff,  acc_w_in;
   logic [31:0] acc_h_ff,  acc_h_in;

   logic [7:0]  b;
   logic [5:0]  png_idx;
   logic [31:0] png_w_base, png_h_base, png_w_next, png_h_next;
   logic        png_bad, png_done;
   logic [15:0] seg_len, cnt_dec;
   logic        is_sof;
   logic        emit_c;
   logic [1:0]  status_c;
   logic [31:0] width_c, height_c;

   assign b = item.data_byte;

   always_comb begin
      png_idx    = (phase_ff == PH_START) ? 6'd0  : count_ff[5:0];
      png_w_base = (phase_ff == PH_START) ? 32'd0 : acc_w_ff;
      png_h_base = (phase_ff == PH_START) ? 32'd0 : acc_h_ff;
      png_bad    = ((png_idx < 6'd8) && (b != ihds_pkg::png_signature_byte(png_idx[2:0]))) ||
                   ((png_idx >= 6'd12) && (png_idx < 6'd16) &&
                    (b != ihds_pkg::png_tag_byte(png_idx[1:0])));
      png_w_next = ((png_idx >= 6'd16) && (png_idx < 6'd20)) ? {png_w_base[23:0], b}
                                                             : png_w_base;
      png_h_next = ((png_idx >= 6'd20) && (png_idx < 6'd24)) ? {png_h_base[23:0], b}
                                                             : png_h_base;
      png_done   = (png_idx >= ihds_pkg::PNG_LAST_INDEX);
      seg_len    = {len_hi_ff, b};
      cnt_dec    = (count_ff != 16'd0) ? (count_ff - 16'd1) : 16'd0;
      is_sof     = ((b & ihds_pkg::JPEG_SOF_MASK) == ihds_pkg::JPEG_SOF_BASE) &&
                   (b != ihds_pkg::JPEG_DHT) && (b != ihds_pkg::JPEG_JPG) &&
                   (b != ihds_pkg::JPEG_DAC);
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      len_hi_in = len_hi_ff;
      acc_w_in  = acc_w_ff;
      acc_h_in  = acc_h_ff;
      emit_c    = 1'b0;
      status_c  = ihds_pkg::STATUS_INVALID;
      width_c   = 32'd0;
      height_c  = 32'd0;

      unique case (phase_ff) inside
         PH_START, PH_PNG: begin
            if ((phase_ff == PH_START) && (format_ff == ihds_pkg::FORMAT_JPEG)) begin
               if (b != ihds_pkg::JPEG_FILL) begin
                  emit_c = 1'b1;
               end else begin
                  phase_in = PH_J_SOI1;
               end
            end else if ((phase_ff == PH_PNG) || (format_ff == ihds_pkg::FORMAT_PNG)) begin
               acc_w_in = png_w_next;
               acc_h_in = png_h_next;
               count_in = {10'd0, png_idx};
               if (png_bad) begin
                  emit_c = 1'b1;
               end else if (png_done) begin
                  emit_c   = 1'b1;
                  status_c = ihds_pkg::STATUS_OK;
                  width_c  = png_w_next;
                  height_c = png_h_next;
               end else begin
                  count_in = {10'd0, png_idx + 6'd1};
                  phase_in = PH_PNG;
               end
            end else begin
               emit_c   = 1'b1;
               status_c = ihds_pkg::STATUS_UNKNOWN;
            end
         end
         PH_J_SOI1: begin
            if (b != ihds_pkg::JPEG_SOI) begin
               emit_c = 1'b1;
            end else begin
               phase_in = PH_J_SEEK;
            end
         end
         PH_J_SEEK: begin
            if (b == ihds_pkg::JPEG_FILL) begin
               phase_in = PH_J_FILL;
            end
         end
         PH_J_FILL: begin
            if (b != ihds_pkg::JPEG_FILL) begin
               if (is_sof) begin
                  count_in = 16'd0;
                  phase_in = PH_J_SOF;
               end else if ((b == ihds_pkg::JPEG_SOI) || (b == ihds_pkg::JPEG_EOI)) begin
                  emit_c = 1'b1;
               end else begin
                  phase_in = PH_J_LENH;
               end
            end
         end
         PH_J_LENH: begin
            len_hi_in = b;
            phase_in  = PH_J_LENL;
         end
         PH_J_LENL: begin
            if (seg_len < 16'd2) begin
               emit_c = 1'b1;
            end else if (seg_len == 16'd2) begin
               phase_in = PH_J_SEEK;
            end else begin
               count_in = seg_len - 16'd2;
               phase_in = PH_J_SKIP;
            end
         end
         PH_J_SKIP: begin
            count_in = cnt_dec;
            if (cnt_dec == 16'd0) begin
               phase_in = PH_J_SEEK;
            end
         end
         PH_J_SOF: begin
            if ((count_ff == 16'd3) || (count_ff == 16'd4)) begin
               acc_h_in = {16'd0, acc_h_ff[7:0], b};
            end else if ((count_ff == 16'd5) || (count_ff == 16'd6)) begin
               acc_w_in = {16'd0, acc_w_ff[7:0], b};
            end
            if (count_ff >= 16'd6) begin
               emit_c   = 1'b1;
               status_c = ihds_pkg::STATUS_OK;
               width_c  = acc_w_in;
               height_c = acc_h_in;
            end else begin
               count_in = count_ff + 16'd1;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (emit_c) begin
         phase_in = PH_DONE;
      end

      if (item.last_byte) begin
         if (!emit_c && (phase_in != PH_DONE)) begin
            emit_c   = 1'b1;
            status_c = ihds_pkg::STATUS_INVALID;
            width_c  = 32'd0;
            height_c = 32'd0;
         end
         phase_in  = PH_START;
         count_in  = 16'd0;
         acc_w_in  = 32'd0;
         acc_h_in  = 32'd0;
         len_hi_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= ihds_pkg::FORMAT_JPEG;
         phase_ff  <= PH_START;
         count_ff  <= 16'd0;
         len_hi_ff <= 8'd0;
         acc_w_ff  <= 32'd0;
         acc_h_ff  <= 32'd0;
      end else begin
         if (csr_wr_en) begin
            format_ff <= csr_wr_data;
         end
         if (advance) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            len_hi_ff <= len_hi_in;
            acc_w_ff  <= acc_w_in;
            acc_h_ff  <= acc_h_in;
         end
      end
   end

   assign parse_out.emit                = advance && emit_c;
   assign parse_out.result.status       = status_c;
   assign parse_out.result.image_width  = width_c;
   assign parse_out.result.image_height = height_c;

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && item.last_byte) |=> (phase_ff == PH_START))
      else $error("last byte did not return the parser to the start phase");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && (phase_ff == PH_DONE) && !item.last_byte) |-> !parse_out.emit)
      else $error("second result for one image");

   a_emit_ends_image: assert property (@(posedge clock) disable iff (reset)
      parse_out.emit |=> ((phase_ff == PH_DONE) || (phase_ff == PH_START)))
      else $error("parser kept walking after a result");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (parse_out.emit && (parse_out.result.status != ihds_pkg::STATUS_OK)) |->
      ((parse_out.result.image_width == 32'd0) && (parse_out.result.image_height == 32'd0)))
      else $error("nonzero dimensions with a failing status");

   a_sof_16bit: assert property (@(posedge clock) disable iff (reset)
      (parse_out.emit && (phase_ff == PH_J_SOF)) |->
      ((parse_out.result.image_width[31:16] == 16'd0) &&
       (parse_out.result.image_height[31:16] == 16'd0)))
      else $error("JPEG dimension wider than 16 bits");

endmodule

// ===== rtl/core/ihds_out_reg.sv =====
// Result register: holds one result transaction until the sink takes it.
// Depends on ihds_pkg and ihds_rsp_if.
`timescale 1ns / 1ps

module ihds_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  ihds_pkg::parse_out_type  parse_out,
   output logic                     free,
   ihds_rsp_if.source               rsp_if
);

   logic                 valid_ff;
   logic                 valid_in;
   ihds_pkg::result_type result_ff;

   assign free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (parse_out.emit) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (parse_out.emit) begin
         result_ff <= parse_out.result;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.status       = result_ff.status;
   assign rsp_if.image_width  = result_ff.image_width;
   assign rsp_if.image_height = result_ff.image_height;

endmodule
